FILE: hw/rtl/rec_pkg.sv
`timescale 1ns / 1ps

package rec_pkg;

	localparam int TIME_W    = 32;
	localparam int LOCKOUT_W = 16;
	localparam int PHASE_W   = 3;
	localparam int TURN_W    = 2;

	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd200;

	// detent phases
	localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_CLK_LOW  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_CLK_BOTH = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CLK_REL  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DAT_LOW  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DAT_BOTH = 3'd5;
	localparam logic [PHASE_W-1:0] PH_DAT_REL  = 3'd6;

	// turn codes
	localparam logic [TURN_W-1:0] TURN_NONE = 2'd0;
	localparam logic [TURN_W-1:0] TURN_CLK  = 2'd1;
	localparam logic [TURN_W-1:0] TURN_DAT  = 2'd2;

endpackage

FILE: hw/rtl/rec_phase.sv
`timescale 1ns / 1ps

module rec_phase
	import rec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              clock_pin,
	input  logic              data_pin,
	output logic [TURN_W-1:0] turn
);

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_nxt;

	always_comb begin
		turn      = TURN_NONE;
		phase_nxt = PH_IDLE;
		unique case (phase_q)
			PH_IDLE: begin
				if (!clock_pin)
					phase_nxt = PH_CLK_LOW;
				else if (!data_pin)
					phase_nxt = PH_DAT_LOW;
				else
					phase_nxt = PH_IDLE;
			end
			PH_CLK_LOW:  phase_nxt = data_pin ? PH_CLK_LOW : PH_CLK_BOTH;
			PH_CLK_BOTH: phase_nxt = clock_pin ? PH_CLK_REL : PH_CLK_BOTH;
			PH_CLK_REL: begin
				if (clock_pin && data_pin) begin
					turn      = TURN_CLK;
					phase_nxt = PH_IDLE;
				end else begin
					phase_nxt = PH_CLK_REL;
				end
			end
			PH_DAT_LOW:  phase_nxt = clock_pin ? PH_DAT_LOW : PH_DAT_BOTH;
			PH_DAT_BOTH: phase_nxt = data_pin ? PH_DAT_REL : PH_DAT_BOTH;
			PH_DAT_REL: begin
				if (clock_pin && data_pin) begin
					turn      = TURN_DAT;
					phase_nxt = PH_IDLE;
				end else begin
					phase_nxt = PH_DAT_REL;
				end
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (adv) begin
			phase_q <= phase_nxt;
		end
	end

endmodule

FILE: hw/rtl/rec_click.sv
`timescale 1ns / 1ps

module rec_click
	import rec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 button_pin,
	input  logic [TIME_W-1:0]    time_ms,
	input  logic [LOCKOUT_W-1:0] lockout_ms,
	output logic                 click
);

	logic [TIME_W-1:0] last_click_q;
	logic              press_seen_q;
	logic              pressed;
	logic [TIME_W-1:0] elapsed;

	assign pressed = !button_pin;
	// wraps modulo 2^32
	assign elapsed = time_ms - last_click_q;
	assign click   = pressed && !press_seen_q && (elapsed > {16'd0, lockout_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_click_q <= '0;
			press_seen_q <= 1'b0;
		end else if (adv) begin
			if (pressed && !press_seen_q) begin
				if (click) begin
					last_click_q <= time_ms;
					press_seen_q <= 1'b1;
				end
			end else begin
				press_seen_q <= pressed;
			end
		end
	end

endmodule

FILE: hw/rtl/rotary_encoder_with_click_lockout.sv
`timescale 1ns / 1ps

// Channel   Handshake              Word
// -------   --------------------   ------------------------------------------
// in        in_valid / in_stall    clock_pin, data_pin, button_pin, time_ms
// out       out_valid / out_stall  turn, click
// cfg       cfg_we                 cfg_wdata -> lockout_ms
//
// One sample word per clock while out is not stalled. A word is held in the input
// register, then the phase machine and click logic update and load the result register,
// which drives out_valid; a stall on out can keep a word in the input register between.
// A stall on out holds the result register and backs up into in_stall only
// when the input register is full too. Reset clears the phase, the click
// history, both valid flags and sets lockout_ms to 200.

module rotary_encoder_with_click_lockout
	import rec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 clock_pin,
	input  logic                 data_pin,
	input  logic                 button_pin,
	input  logic [TIME_W-1:0]    time_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [TURN_W-1:0]    turn,
	output logic                 click,
	input  logic                 cfg_we,
	input  logic [LOCKOUT_W-1:0] cfg_wdata
);

	logic [LOCKOUT_W-1:0] lockout_q;

	// input register
	logic                 valid_s1;
	logic                 clock_pin_s1;
	logic                 data_pin_s1;
	logic                 button_pin_s1;
	logic [TIME_W-1:0]    time_ms_s1;

	// result register
	logic                 out_valid_q;
	logic [TURN_W-1:0]    turn_q;
	logic                 click_q;

	logic                 stall_s1;
	logic                 adv;
	logic                 in_acc;
	logic [TURN_W-1:0]    turn_nxt;
	logic                 click_nxt;

	// the result register is free when empty or being drained this cycle
	assign stall_s1 = out_valid_q && out_stall;
	assign adv      = valid_s1 && !stall_s1;
	assign in_stall = valid_s1 && stall_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RESET;
		end else if (cfg_we) begin
			lockout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			clock_pin_s1  <= clock_pin;
			data_pin_s1   <= data_pin;
			button_pin_s1 <= button_pin;
			time_ms_s1    <= time_ms;
		end
	end

	rec_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.clock_pin (clock_pin_s1),
		.data_pin  (data_pin_s1),
		.turn      (turn_nxt)
	);

	rec_click u_click (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.button_pin (button_pin_s1),
		.time_ms    (time_ms_s1),
		.lockout_ms (lockout_q),
		.click      (click_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			turn_q  <= turn_nxt;
			click_q <= click_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign turn      = turn_q;
	assign click     = click_q;

endmodule

FILE: test/rotary_encoder_with_click_lockout_test.sv
`timescale 1ns / 1ps

// Bench for the encoder decoder. A scoreboard-side copy of the detent machine and
// the click lockout predicts every result word. The bench runs a directed table first,
// then random pin traffic under three lockout settings and three idling mixes.
module rotary_encoder_with_click_lockout_test;
	import rec_pkg::*;

	typedef struct packed {
		logic [TURN_W-1:0] turn;
		logic              click;
	} result_t;

	// One directed row: pin levels, timestamp, and an optional hand-typed result.
	typedef struct packed {
		logic              ck;
		logic              dt;
		logic              bt;
		logic [TIME_W-1:0] t;
		logic              has;
		logic [TURN_W-1:0] e_turn;
		logic              e_click;
	} dir_row_t;

	// Pin pairs {clock, data} of one detent, first step in the low bits.
	localparam logic [7:0] CW_SEQ  = 8'b11_10_00_01;
	localparam logic [7:0] CCW_SEQ = 8'b11_01_00_10;
	localparam int         HOLD_CYCLES = 40;
	localparam int         N_DIR = 23;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 clock_pin = 1'b1;
	logic                 data_pin = 1'b1;
	logic                 button_pin = 1'b1;
	logic [TIME_W-1:0]    time_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [TURN_W-1:0]    turn;
	logic                 click;
	logic                 cfg_we = 1'b0;
	logic [LOCKOUT_W-1:0] cfg_wdata = '0;

	// Sideband that travels with the driven word: a typed result, if the row has one.
	logic    drv_has_exp = 1'b0;
	result_t drv_exp = '0;

	// Detent and click state as the block should hold it.
	logic [PHASE_W-1:0]   det_phase = PH_IDLE;
	logic [TIME_W-1:0]    last_click_ms = '0;
	logic                 press_held = 1'b0;
	logic [LOCKOUT_W-1:0] lockout_cur = LOCKOUT_RESET;

	result_t exp_q[$];
	result_t got_res, want_res;
	int      sent_cnt = 0;
	int      done_cnt = 0;
	int      err_cnt = 0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	// Random pin traffic state.
	logic [1:0]        lvl_q[$];
	logic              btn_lvl = 1'b1;
	int                btn_left = 0;
	logic [TIME_W-1:0] now_ms = '0;

	// Directed rows. Reset lockout is 200 ms.
	dir_row_t dir_tab [N_DIR] = '{
		'{1'b1, 1'b1, 1'b1, 32'd0,          1'b1, TURN_NONE, 1'b0}, // idle after reset
		'{1'b1, 1'b1, 1'b0, 32'd100,        1'b1, TURN_NONE, 1'b0}, // press inside lockout
		'{1'b1, 1'b1, 1'b0, 32'd200,        1'b1, TURN_NONE, 1'b0}, // elapsed equal: no click
		'{1'b1, 1'b1, 1'b0, 32'd201,        1'b1, TURN_NONE, 1'b1}, // retried press clicks
		'{1'b1, 1'b1, 1'b0, 32'd9000,       1'b1, TURN_NONE, 1'b0}, // still held: silent
		'{1'b0, 1'b1, 1'b1, 32'd9001,       1'b0, TURN_NONE, 1'b0}, // clock-first detent
		'{1'b0, 1'b0, 1'b1, 32'd9002,       1'b0, TURN_NONE, 1'b0},
		'{1'b1, 1'b0, 1'b1, 32'd9003,       1'b0, TURN_NONE, 1'b0},
		'{1'b1, 1'b1, 1'b1, 32'd9004,       1'b1, TURN_CLK,  1'b0},
		'{1'b1, 1'b0, 1'b1, 32'd9005,       1'b0, TURN_NONE, 1'b0}, // data-first detent
		'{1'b0, 1'b0, 1'b1, 32'd9006,       1'b0, TURN_NONE, 1'b0},
		'{1'b0, 1'b1, 1'b1, 32'd9007,       1'b0, TURN_NONE, 1'b0},
		'{1'b1, 1'b1, 1'b1, 32'd9008,       1'b1, TURN_DAT,  1'b0},
		'{1'b0, 1'b0, 1'b1, 32'd9009,       1'b0, TURN_NONE, 1'b0}, // both low: clock wins
		'{1'b1, 1'b1, 1'b1, 32'd9010,       1'b0, TURN_NONE, 1'b0},
		'{1'b0, 1'b0, 1'b1, 32'd9011,       1'b0, TURN_NONE, 1'b0},
		'{1'b1, 1'b1, 1'b1, 32'd9012,       1'b0, TURN_NONE, 1'b0},
		'{1'b1, 1'b1, 1'b1, 32'd9013,       1'b0, TURN_NONE, 1'b0},
		'{1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF,  1'b1, TURN_NONE, 1'b1}, // top of time range
		'{1'b1, 1'b1, 1'b1, 32'd0,          1'b1, TURN_NONE, 1'b0},
		'{1'b1, 1'b1, 1'b0, 32'd100,        1'b1, TURN_NONE, 1'b0}, // across wrap: 101 ms
		'{1'b1, 1'b1, 1'b0, 32'd201,        1'b1, TURN_NONE, 1'b1}, // across wrap: 202 ms
		'{1'b1, 1'b1, 1'b1, 32'd202,        1'b0, TURN_NONE, 1'b0}
	};

	rotary_encoder_with_click_lockout u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.clock_pin  (clock_pin),
		.data_pin   (data_pin),
		.button_pin (button_pin),
		.time_ms    (time_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.turn       (turn),
		.click      (click),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Next result for one accepted sample; updates the predicted state.
	function automatic result_t decode_sample(input logic ck, input logic dt, input logic bt,
			input logic [TIME_W-1:0] t);
		result_t           r;
		logic [TIME_W-1:0] elapsed;
		r.turn  = TURN_NONE;
		r.click = 1'b0;
		// modulo-2^32 difference, strictly greater than the lockout
		elapsed = t - last_click_ms;
		if (!bt && !press_held) begin
			if (elapsed > TIME_W'(lockout_cur)) begin
				last_click_ms = t;
				r.click       = 1'b1;
				press_held    = 1'b1;
			end
		end else begin
			press_held = !bt;
		end
		case (det_phase)
			PH_IDLE: begin
				if (!ck)
					det_phase = PH_CLK_LOW;
				else if (!dt)
					det_phase = PH_DAT_LOW;
			end
			PH_CLK_LOW:  if (!dt) det_phase = PH_CLK_BOTH;
			PH_CLK_BOTH: if (ck) det_phase = PH_CLK_REL;
			PH_CLK_REL: begin
				if (ck && dt) begin
					det_phase = PH_IDLE;
					r.turn    = TURN_CLK;
				end
			end
			PH_DAT_LOW:  if (!ck) det_phase = PH_DAT_BOTH;
			PH_DAT_BOTH: if (dt) det_phase = PH_DAT_REL;
			PH_DAT_REL: begin
				if (ck && dt) begin
					det_phase = PH_IDLE;
					r.turn    = TURN_DAT;
				end
			end
			default: det_phase = PH_IDLE;
		endcase
		return r;
	endfunction

	task automatic note_mismatch(input string what, input result_t w, input result_t g);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t %s: expected turn=%0d click=%0d, got turn=%0d click=%0d",
				$realtime, what, w.turn, w.click, g.turn, g.click);
	endtask

	// Scoreboard. Output side first, then input side, both on pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_res = '{turn: turn, click: click};
				if (exp_q.size() == 0) begin
					note_mismatch("result word with nothing expected", '0, got_res);
				end else begin
					want_res = exp_q.pop_front();
					done_cnt++;
					if (got_res.turn !== want_res.turn)
						note_mismatch("turn mismatch", want_res, got_res);
					if (got_res.click !== want_res.click)
						note_mismatch("click mismatch", want_res, got_res);
				end
			end
			if (in_valid && !in_stall) begin
				want_res = decode_sample(clock_pin, data_pin, button_pin, time_ms);
				// typed rows override; the predictor still steps to keep state
				if (drv_has_exp)
					want_res = drv_exp;
				exp_q.push_back(want_res);
			end
		end
	end

	// Receiver: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_ack  <= hold_req;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Offer one word and return at the edge that accepts it. valid stays high on
	// return, so a back-to-back word never drops it for a step.
	task automatic send_word(input logic ck, input logic dt, input logic bt,
			input logic [TIME_W-1:0] t, input logic has, input result_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		clock_pin   <= ck;
		data_pin    <= dt;
		button_pin  <= bt;
		time_ms     <= t;
		drv_has_exp <= has;
		drv_exp     <= want;
		do
			@(posedge clk);
		while (in_stall);
		sent_cnt++;
	endtask

	// Sender goes quiet until every outstanding result word has been checked.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (done_cnt != sent_cnt)
			@(posedge clk);
	endtask

	task automatic write_lockout(input logic [LOCKOUT_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		lockout_cur  = v;
		@(posedge clk);
		cfg_we      <= 1'b0;
	endtask

	// Mostly whole detents with random dwell, some cut short, some pin noise.
	// Button toggles with random hold lengths; time mostly creeps forward at a
	// pace scaled to the lockout, with rare jumps and stops near the wrap.
	task automatic next_sample(output logic ck, output logic dt, output logic bt,
			output logic [TIME_W-1:0] t);
		logic [1:0] pair;
		int         r;
		int         n;
		logic       cw;
		if (lvl_q.size() == 0) begin
			r = $urandom_range(99);
			if (r < 65) begin
				cw = 1'($urandom_range(1));
				n  = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 4;
				for (int i = 0; i < n; i++)
					repeat ($urandom_range(1, 3))
						lvl_q.push_back(cw ? CW_SEQ[2*i +: 2] : CCW_SEQ[2*i +: 2]);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 4))
					lvl_q.push_back(2'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					lvl_q.push_back(2'b11);
			end
		end
		pair = lvl_q.pop_front();
		if (btn_left == 0) begin
			btn_lvl  = !btn_lvl;
			btn_left = $urandom_range(1, 12);
		end
		btn_left--;
		r = $urandom_range(99);
		if (r < 4)
			now_ms = $urandom;
		else if (r < 7)
			now_ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
		else
			now_ms = now_ms + $urandom_range(0, lockout_cur / 6 + 3);
		ck = pair[1];
		dt = pair[0];
		bt = btn_lvl;
		t  = now_ms;
	endtask

	task automatic run_random(input int n, input int tx_pct, input int rx_pct);
		logic              ck, dt, bt;
		logic [TIME_W-1:0] t;
		tx_idle_pct  = tx_pct;
		rx_idle_pct <= rx_pct;
		repeat (n) begin
			next_sample(ck, dt, bt, t);
			send_word(ck, dt, bt, t, 1'b0, '0);
		end
	endtask

	// Hard stop in case a handshake never completes.
	initial begin
		#3_000_000;
		$display("FAIL rotary_encoder_with_click_lockout");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the first idling mix
		tx_idle_pct  = 19;
		rx_idle_pct <= 63;
		for (int i = 0; i < N_DIR; i++)
			send_word(dir_tab[i].ck, dir_tab[i].dt, dir_tab[i].bt, dir_tab[i].t,
				dir_tab[i].has, {dir_tab[i].e_turn, dir_tab[i].e_click});

		// no lockout at all: any later press clicks, a same-ms retry does not
		write_lockout('0);
		run_random(170, 19, 63);

		// widest lockout, idling swapped
		write_lockout('1);
		run_random(170, 63, 19);

		// mid lockout, no idling
		write_lockout(LOCKOUT_W'($urandom_range(1, 65534)));
		run_random(100, 0, 0);

		// long receiver hold-off while words keep coming: block fills, in_stall rises
		hold_req <= hold_req + 1;
		run_random(30, 0, 0);
		wait_idle();
		run_random(70, 0, 0);

		wait_idle();
		repeat (8) @(posedge clk);
		if (exp_q.size() != 0) begin
			err_cnt++;
			$display("%0d result words never arrived", exp_q.size());
		end
		if (err_cnt == 0)
			$display("PASS rotary_encoder_with_click_lockout");
		else
			$display("FAIL rotary_encoder_with_click_lockout");
		$finish;
	end

endmodule
